// ===== hw/rtl/sptm_pkg.sv =====
package sptm_pkg;

  // Field widths
  localparam int COEF_W = 32;
  localparam int EXP_W  = 16;
  localparam int SUM_W  = COEF_W + 1;

  // Stream widths, padded to whole bytes
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 56;
  localparam int M_PAD_W  = M_DATA_W - SUM_W - EXP_W;

  // Command codes carried on s_tuser
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  // One stored term, coefficient in the low bits
  typedef struct packed {
    logic [EXP_W-1:0]  exponent;
    logic [COEF_W-1:0] coef;
  } term_t;

  // Merge sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FETCH  = 4'b0010,
    ST_CMP    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // Status from the merge sequencer to the load side
  typedef struct packed {
    logic busy;
    logic done;
  } merge_stat_t;

endpackage

// ===== hw/rtl/sptm_store.sv =====
module sptm_store
  import sptm_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  term_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output term_t             rdata
);

  term_t mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sptm_merge.sv =====
module sptm_merge
  import sptm_pkg::*;
#(
  parameter int MAX_TERMS = 32,
  parameter int CNT_W     = $clog2(MAX_TERMS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CNT_W-1:0]    cnt_a,
  input  logic [CNT_W-1:0]    cnt_b,
  input  logic                dropped,
  input  term_t               a_rd,
  input  term_t               b_rd,
  output logic [CNT_W-1:0]    idx_a,
  output logic [CNT_W-1:0]    idx_b,
  output merge_stat_t         stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // sum_coef, sum_exponent, zero pad
  output logic [1:0]          m_tuser,  // result_empty, load_overflow
  output logic                m_tlast
);

  state_t state;

  // Pending term: held back until it is known whether another follows
  logic              pend_valid;
  logic [SUM_W-1:0]  pend_coef;
  logic [EXP_W-1:0]  pend_exp;

  logic              have_a, have_b, a_gt, a_lt, take_a, take_b;
  logic [SUM_W-1:0]  op_a, op_b, sum;
  logic              cand_keep, out_free, stall, step;
  logic              push, push_last, push_empty;
  logic [SUM_W-1:0]  push_coef;
  logic [EXP_W-1:0]  push_exp;

  // Head compare and shared adder
  always_comb begin
    have_a    = idx_a < cnt_a;
    have_b    = idx_b < cnt_b;
    a_gt      = a_rd.exponent > b_rd.exponent;
    a_lt      = a_rd.exponent < b_rd.exponent;
    take_a    = have_a && (!have_b || !a_lt);
    take_b    = have_b && (!have_a || !a_gt);
    op_a      = take_a ? {a_rd.coef[COEF_W-1], a_rd.coef} : '0;
    op_b      = take_b ? {b_rd.coef[COEF_W-1], b_rd.coef} : '0;
    sum       = op_a + op_b;
    cand_keep = !(take_a && take_b) || (sum != '0);
    out_free  = !m_tvalid || m_tready;
    stall     = cand_keep && pend_valid && !out_free;
    step      = (state == ST_CMP) && (have_a || have_b) && !stall;
  end

  // What goes into the output register this cycle
  always_comb begin
    push       = 1'b0;
    push_last  = 1'b0;
    push_empty = 1'b0;
    push_coef  = pend_coef;
    push_exp   = pend_exp;
    if (step && cand_keep && pend_valid) begin
      push = 1'b1;
    end else if (state == ST_FINISH && out_free) begin
      push      = 1'b1;
      push_last = 1'b1;
      if (!pend_valid) begin
        push_empty = 1'b1;
        push_coef  = '0;
        push_exp   = '0;
      end
    end
  end

  assign stat.busy = (state != ST_IDLE);
  assign stat.done = (state == ST_FINISH) && out_free;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx_a      <= '0;
      idx_b      <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (!have_a && !have_b) begin
            state <= ST_FINISH;
          end else if (!stall) begin
            idx_a <= idx_a + CNT_W'(take_a);
            idx_b <= idx_b + CNT_W'(take_b);
            if (cand_keep) begin
              pend_valid <= 1'b1;
            end
            state <= ST_FETCH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            idx_a      <= '0;
            idx_b      <= '0;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Pending term payload
  always_ff @(posedge clk) begin
    if (step && cand_keep) begin
      pend_coef <= sum;
      pend_exp  <= take_a ? a_rd.exponent : b_rd.exponent;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= {{M_PAD_W{1'b0}}, push_exp, push_coef};
      m_tuser <= {dropped, push_empty};
      m_tlast <= push_last;
    end
  end

endmodule

// ===== hw/rtl/sparse_poly_term_merge_add_core.sv =====
// Sparse polynomial adder. Beats on the slave side load terms into store A
// (command 0) or store B (command 1), back to back while idle, or start a run
// (command 2). Terms are expected in descending exponent order per store; the
// order is not checked. A run merges the two stores: the larger exponent goes
// out first, equal exponents are summed and a zero sum is dropped. Each kept
// term is one master beat; the final beat carries tlast, and a run with no
// terms gives a single beat flagged empty with zero data. Loads into a full
// store are dropped and flagged on every beat of the next run. Each merge step
// of a run first reads the heads through each store's registered read port,
// then compares and adds them in the shared unit; the master side can stall a
// run, and s_tready is low throughout. Counts and the overflow flag clear after
// a run.
module sparse_poly_term_merge_add_core
  import sptm_pkg::*;
#(
  parameter int MAX_TERMS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // term_coef, term_exponent
  input  logic [1:0]          s_tuser,   // command
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // sum_coef, sum_exponent, zero pad
  output logic [1:0]          m_tuser,   // result_empty, load_overflow
  output logic                m_tlast
);

  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic [CNT_W-1:0] cnt_a, cnt_b, idx_a, idx_b;
  logic             dropped;
  merge_stat_t      stat;
  term_t            term_in, a_rd, b_rd;
  logic             acc, we_a, we_b, full_a, full_b, start;

  // Load path decode
  always_comb begin
    term_in  = term_t'(s_tdata);
    s_tready = !stat.busy;
    acc      = s_tvalid && s_tready;
    full_a   = cnt_a >= CNT_W'(MAX_TERMS);
    full_b   = cnt_b >= CNT_W'(MAX_TERMS);
    we_a     = acc && (s_tuser == CMD_LOAD_A) && !full_a;
    we_b     = acc && (s_tuser == CMD_LOAD_B) && !full_b;
    start    = acc && (s_tuser == CMD_RUN);
  end

  // Fill counts and overflow flag
  always_ff @(posedge clk) begin
    if (rst || stat.done) begin
      cnt_a   <= '0;
      cnt_b   <= '0;
      dropped <= 1'b0;
    end else begin
      if (we_a) begin
        cnt_a <= cnt_a + CNT_W'(1);
      end
      if (we_b) begin
        cnt_b <= cnt_b + CNT_W'(1);
      end
      if (acc && ((s_tuser == CMD_LOAD_A && full_a) ||
                  (s_tuser == CMD_LOAD_B && full_b))) begin
        dropped <= 1'b1;
      end
    end
  end

  sptm_store #(.DEPTH(MAX_TERMS), .ADDR_W(ADDR_W)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a[ADDR_W-1:0]),
    .wdata (term_in),
    .raddr (idx_a[ADDR_W-1:0]),
    .rdata (a_rd)
  );

  sptm_store #(.DEPTH(MAX_TERMS), .ADDR_W(ADDR_W)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b[ADDR_W-1:0]),
    .wdata (term_in),
    .raddr (idx_b[ADDR_W-1:0]),
    .rdata (b_rd)
  );

  sptm_merge #(.MAX_TERMS(MAX_TERMS), .CNT_W(CNT_W)) u_merge (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cnt_a    (cnt_a),
    .cnt_b    (cnt_b),
    .dropped  (dropped),
    .a_rd     (a_rd),
    .b_rd     (b_rd),
    .idx_a    (idx_a),
    .idx_b    (idx_b),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
